// File: rtl/core/mvma_pkg.sv
package mvma_pkg;

  // Fixed field widths of the block's interface.
  localparam int IDX_W     = 6;   // row, column, position and result indexes
  localparam int CNT_W     = 7;   // row_count and col_count registers
  localparam int MODE_W    = 2;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 7;   // widest configuration register
  localparam int ACC_W     = 40;  // Q24.16 accumulator
  localparam int FRAC_BITS = 8;   // fraction bits of one Q8.8 element

  // Input opcodes.
  localparam logic [OP_W-1:0] OP_WR_MATRIX = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_VECTOR = 2'd1;
  localparam logic [OP_W-1:0] OP_WR_BIAS   = 2'd2;
  localparam logic [OP_W-1:0] OP_COMPUTE   = 2'd3;

  // Modes. The remaining code behaves as MODE_MXV.
  localparam logic [MODE_W-1:0] MODE_MXV      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MXV_BIAS = 2'd1;
  localparam logic [MODE_W-1:0] MODE_VXM      = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             wr_matrix;
    logic             wr_vector;
    logic             wr_bias;
    logic             issue;       // read one matrix/vector pair into the MAC pipe
    logic             clear_acc;   // start a new dot product
    logic             load_out;    // move the finished sum into the output register
    logic             last;        // final output element of this compute
    logic             transposed;  // vector times matrix
    logic             bias_en;     // add the bias element on load_out
    logic [IDX_W-1:0] outer;       // output element index
    logic [IDX_W-1:0] inner;       // term index within the dot product
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pipe_busy;  // terms still in flight through the MAC pipe
    logic out_free;   // the output register can take a new result this cycle
  } status_t;

endpackage

// File: rtl/core/mvma_ctrl.sv
module mvma_ctrl #(
  parameter int MAX_DIM = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [mvma_pkg::OP_W-1:0]       opcode,
  output logic                            in_stall,
  input  logic                            cfg_we,
  input  logic [mvma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mvma_pkg::CFG_W-1:0]      cfg_data,
  input  mvma_pkg::status_t               status,
  output mvma_pkg::cmd_t                  cmd
);

  localparam int IW = mvma_pkg::IDX_W;
  localparam int CW = mvma_pkg::CNT_W;
  localparam int MW = mvma_pkg::MODE_W;
  localparam logic [CW-1:0] DIM_MAX = CW'(MAX_DIM);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] row_count;
  logic [CW-1:0] col_count;
  logic [MW-1:0] mode;
  logic          transposed, transposed_next;
  logic          bias_en, bias_en_next;
  logic [IW-1:0] outer, outer_next;
  logic [IW-1:0] inner, inner_next;
  logic [IW-1:0] outer_last, outer_last_next;
  logic [IW-1:0] inner_last, inner_last_next;
  logic [IW-1:0] rows_m1;
  logic [IW-1:0] cols_m1;
  logic          mode_vxm;

  // Size in use minus one, with zero acting as one and oversize as MAX_DIM.
  function automatic logic [IW-1:0] dim_m1(input logic [CW-1:0] d);
    logic [CW-1:0] c;
    begin
      c = d;
      if (d == '0) begin
        c = CW'(1);
      end else if (d > DIM_MAX) begin
        c = DIM_MAX;
      end
      return IW'(c - CW'(1));
    end
  endfunction

  assign rows_m1  = dim_m1(row_count);
  assign cols_m1  = dim_m1(col_count);
  assign mode_vxm = (mode == mvma_pkg::MODE_VXM);

  always_comb begin
    state_next      = state;
    transposed_next = transposed;
    bias_en_next    = bias_en;
    outer_next      = outer;
    inner_next      = inner;
    outer_last_next = outer_last;
    inner_last_next = inner_last;
    in_stall        = (state != ST_IDLE);
    cmd             = '0;
    cmd.outer       = outer;
    cmd.inner       = inner;
    cmd.transposed  = transposed;
    cmd.bias_en     = bias_en;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (opcode)
            mvma_pkg::OP_WR_MATRIX: cmd.wr_matrix = 1'b1;
            mvma_pkg::OP_WR_VECTOR: cmd.wr_vector = 1'b1;
            mvma_pkg::OP_WR_BIAS:   cmd.wr_bias   = 1'b1;
            default: begin
              cmd.clear_acc   = 1'b1;
              transposed_next = mode_vxm;
              bias_en_next    = (mode == mvma_pkg::MODE_MXV_BIAS);
              outer_last_next = mode_vxm ? cols_m1 : rows_m1;
              inner_last_next = mode_vxm ? rows_m1 : cols_m1;
              outer_next      = '0;
              inner_next      = '0;
              state_next      = ST_ISSUE;
            end
          endcase
        end
      end
      ST_ISSUE: begin
        cmd.issue  = 1'b1;
        inner_next = inner + IW'(1);
        if (inner == inner_last) begin
          inner_next = '0;
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy && status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.last     = (outer == outer_last);
          if (outer == outer_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.clear_acc = 1'b1;
            outer_next    = outer + IW'(1);
            state_next    = ST_ISSUE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_count <= CW'(1);
      col_count <= CW'(1);
      mode      <= mvma_pkg::MODE_MXV;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          mvma_pkg::CFG_ROW_COUNT: row_count <= cfg_data[CW-1:0];
          mvma_pkg::CFG_COL_COUNT: col_count <= cfg_data[CW-1:0];
          mvma_pkg::CFG_MODE:      mode      <= cfg_data[MW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    transposed <= transposed_next;
    bias_en    <= bias_en_next;
    outer      <= outer_next;
    inner      <= inner_next;
    outer_last <= outer_last_next;
    inner_last <= inner_last_next;
  end

endmodule

// File: rtl/core/mvma_datapath.sv
module mvma_datapath #(
  parameter int MAX_DIM    = 64,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mvma_pkg::cmd_t                     cmd,
  output mvma_pkg::status_t                  status,
  input  logic [mvma_pkg::IDX_W-1:0]         row_index,
  input  logic [mvma_pkg::IDX_W-1:0]         col_index,
  input  logic [mvma_pkg::IDX_W-1:0]         position,
  input  logic signed [ELEM_WIDTH-1:0]       element_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mvma_pkg::IDX_W-1:0]         result_index,
  output logic signed [mvma_pkg::ACC_W-1:0]  result_value,
  output logic                               last
);

  localparam int IW        = mvma_pkg::IDX_W;
  localparam int AW        = mvma_pkg::ACC_W;
  localparam int LIN_W     = 2 * IW;
  localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;
  localparam int MAT_AW    = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
  localparam int VEC_AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic [IW:0] DIM_LIMIT = (IW + 1)'(MAX_DIM);

  logic signed [ELEM_WIDTH-1:0]   mat_mem  [MAT_DEPTH];
  logic signed [ELEM_WIDTH-1:0]   vec_mem  [MAX_DIM];
  logic signed [ELEM_WIDTH-1:0]   bias_mem [MAX_DIM];

  logic signed [ELEM_WIDTH-1:0]   mat_rdata;
  logic signed [ELEM_WIDTH-1:0]   vec_rdata;
  logic signed [ELEM_WIDTH-1:0]   bias_rdata;
  logic signed [2*ELEM_WIDTH-1:0] prod;
  logic [AW-1:0]                  acc;
  logic [AW-1:0]                  bias_term;
  logic                           rd_valid;
  logic                           prod_valid;

  logic [LIN_W-1:0] wr_lin;
  logic [LIN_W-1:0] rd_lin;
  logic             row_ok;
  logic             col_ok;
  logic             pos_ok;

  assign row_ok = ({1'b0, row_index} < DIM_LIMIT);
  assign col_ok = ({1'b0, col_index} < DIM_LIMIT);
  assign pos_ok = ({1'b0, position} < DIM_LIMIT);

  // Row-major layout with a fixed pitch of MAX_DIM.
  assign wr_lin = LIN_W'(LIN_W'(row_index) * LIN_W'(MAX_DIM) + LIN_W'(col_index));
  assign rd_lin = cmd.transposed
                ? LIN_W'(LIN_W'(cmd.inner) * LIN_W'(MAX_DIM) + LIN_W'(cmd.outer))
                : LIN_W'(LIN_W'(cmd.outer) * LIN_W'(MAX_DIM) + LIN_W'(cmd.inner));

  always_ff @(posedge clk) begin
    if (cmd.wr_matrix && row_ok && col_ok) begin
      mat_mem[wr_lin[MAT_AW-1:0]] <= element_value;
    end
    mat_rdata <= mat_mem[rd_lin[MAT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_vector && pos_ok) begin
      vec_mem[position[VEC_AW-1:0]] <= element_value;
    end
    vec_rdata <= vec_mem[cmd.inner[VEC_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_bias && pos_ok) begin
      bias_mem[position[VEC_AW-1:0]] <= element_value;
    end
    bias_rdata <= bias_mem[cmd.outer[VEC_AW-1:0]];
  end

  // Multiply and accumulate, one stage each.
  always_ff @(posedge clk) begin
    prod <= mat_rdata * vec_rdata;
    if (cmd.clear_acc) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + AW'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      rd_valid   <= cmd.issue;
      prod_valid <= rd_valid;
    end
  end

  assign bias_term = cmd.bias_en ? (AW'(bias_rdata) << mvma_pkg::FRAC_BITS) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result_index <= cmd.outer;
      result_value <= acc + bias_term;
      last         <= cmd.last;
    end
  end

  assign status.pipe_busy = rd_valid || prod_valid;
  assign status.out_free  = !out_valid || !out_stall;

endmodule

// File: rtl/core/matrix_vector_multiply_add.sv
// Fixed-point dense matrix-vector engine. Load items (opcode write matrix, write
// vector, write bias) store one signed Q8.8 element each and are taken one per
// cycle; a write whose index is not below MAX_DIM is dropped. A compute item
// then returns one exact Q24.16 sum per output element, in index order, with
// last set on the final one: mode 0 gives M*v over row_count results, mode 1
// adds the bias element, mode 2 gives v*M over col_count results (mode 3 acts
// as mode 0, and a size of 0 acts as 1, above MAX_DIM as MAX_DIM). Stores come
// up undefined after reset, so every entry a compute touches must be written
// first. A compute keeps in_stall high while it runs, also while a finished
// result waits because the output register still holds an untaken one: the
// terms go through one multiply-accumulate unit at one per cycle, fed by the
// single read port of the matrix memory, and each result then waits for the
// memory read, multiply and accumulate stages to drain. Results leave through
// an output register, so the next result is computed while the previous one
// waits for its transfer. The user writes configuration only while idle; the
// block itself does not enforce it.
module matrix_vector_multiply_add #(
  parameter int MAX_DIM    = 64,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,

  // Configuration write port.
  input  logic                               cfg_we,
  input  logic [mvma_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mvma_pkg::CFG_W-1:0]         cfg_data,

  // Input channel.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [mvma_pkg::OP_W-1:0]          opcode,
  input  logic [mvma_pkg::IDX_W-1:0]         row_index,
  input  logic [mvma_pkg::IDX_W-1:0]         col_index,
  input  logic [mvma_pkg::IDX_W-1:0]         position,
  input  logic signed [ELEM_WIDTH-1:0]       element_value,

  // Result channel.
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mvma_pkg::IDX_W-1:0]         result_index,
  output logic signed [mvma_pkg::ACC_W-1:0]  result_value,
  output logic                               last
);

  mvma_pkg::cmd_t    ctrl_cmd;
  mvma_pkg::status_t dp_status;

  // The controller sequences loads and the compute loop over output elements
  // and terms; it never touches data.
  mvma_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .in_stall  (in_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (dp_status),
    .cmd       (ctrl_cmd)
  );

  // The datapath holds the three stores, the multiply-accumulate pipe and the
  // output register.
  mvma_datapath #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (ctrl_cmd),
    .status        (dp_status),
    .row_index     (row_index),
    .col_index     (col_index),
    .position      (position),
    .element_value (element_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_index  (result_index),
    .result_value  (result_value),
    .last          (last)
  );

`ifndef SYNTHESIS
  // A sum must never be taken while terms are still in flight.
  a_load_after_drain: assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.load_out |-> !dp_status.pipe_busy)
    else $error("result loaded while MAC pipe busy");

  // Term reads and store writes never share a cycle.
  a_no_write_during_issue: assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.issue |-> !(ctrl_cmd.wr_matrix || ctrl_cmd.wr_vector || ctrl_cmd.wr_bias))
    else $error("store write during term issue");

  // A loaded result is presented on the next cycle.
  a_load_shows_result: assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

  // No input transfer is taken while a compute is running.
  a_stall_while_issue: assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.issue |-> in_stall)
    else $error("input not stalled during compute");
`endif

endmodule

// File: verif/matrix_vector_multiply_add_test.sv
module matrix_vector_multiply_add_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mvma_pkg::*;

  localparam int MAX_DIM = 64;
  localparam int ELEM_W = 16;
  localparam int CLK_PERIOD = 8;

  // Cycles allowed after the last result before the block is taken as idle.
  localparam int SETTLE_CYCLES = 8;

  // The slowest correct run sends a few hundred items with random gaps between
  // bursts, and a few dozen computes of at most 64 results of 64 terms each,
  // whose results wait out long stall runs. That stays far below this figure.
  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  // The directed part sends most of the items; the random part adds the rest.
  localparam int RANDOM_ITEMS = 40;
  localparam int MAX_REPORTS = 100;

  // The configuration index that decodes to no register, and the mode code
  // that behaves as matrix times vector.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct {
    logic [IDX_W-1:0]        index;
    logic signed [ACC_W-1:0] sum;
    logic                    last;
  } gemv_out_t;

  // Keeps its own copy of the three stores and the registers, works out the
  // sums that each compute must return, and matches them against the result
  // transfers in order.
  class gemv_checker;
    logic signed [ELEM_W-1:0] mat_mem [MAX_DIM*MAX_DIM];
    logic signed [ELEM_W-1:0] vec_mem [MAX_DIM];
    logic signed [ELEM_W-1:0] bias_mem [MAX_DIM];
    logic [CNT_W-1:0]  rows_reg;
    logic [CNT_W-1:0]  cols_reg;
    logic [MODE_W-1:0] mode_reg;
    gemv_out_t expected_sums[$];
    int errors;

    function new();
      rows_reg = CNT_W'(1);
      cols_reg = CNT_W'(1);
      mode_reg = MODE_MXV;
      errors = 0;
    endfunction

    function int dim_of(logic [CNT_W-1:0] d);
      if (d == 0) return 1;
      if (d > MAX_DIM) return MAX_DIM;
      return int'(d);
    endfunction

    function logic [MODE_W-1:0] active_mode();
      if (mode_reg == MODE_MXV_BIAS || mode_reg == MODE_VXM) return mode_reg;
      return MODE_MXV;
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
      case (index)
        CFG_ROW_COUNT: rows_reg = data[CNT_W-1:0];
        CFG_COL_COUNT: cols_reg = data[CNT_W-1:0];
        CFG_MODE:      mode_reg = data[MODE_W-1:0];
        default: ;
      endcase
    endfunction

    function void compute_sums();
      int n_out;
      int n_in;
      logic [MODE_W-1:0] m;
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] a;
      logic signed [ACC_W-1:0] b;
      gemv_out_t res;
      m = active_mode();
      n_out = (m == MODE_VXM) ? dim_of(cols_reg) : dim_of(rows_reg);
      n_in = (m == MODE_VXM) ? dim_of(rows_reg) : dim_of(cols_reg);
      for (int i = 0; i < n_out; i++) begin
        acc = '0;
        for (int k = 0; k < n_in; k++) begin
          if (m == MODE_VXM) begin
            a = ACC_W'(vec_mem[k]);
            b = ACC_W'(mat_mem[k*MAX_DIM + i]);
          end else begin
            a = ACC_W'(mat_mem[i*MAX_DIM + k]);
            b = ACC_W'(vec_mem[k]);
          end
          acc = acc + a * b;
        end
        if (m == MODE_MXV_BIAS) begin
          a = ACC_W'(bias_mem[i]);
          acc = acc + (a <<< FRAC_BITS);
        end
        res.index = IDX_W'(i);
        res.sum = acc;
        res.last = (i == n_out - 1);
        expected_sums.push_back(res);
      end
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] r, c, p,
                            logic signed [ELEM_W-1:0] value);
      case (op)
        OP_WR_MATRIX: mat_mem[{r, c}] = value;
        OP_WR_VECTOR: vec_mem[p] = value;
        OP_WR_BIAS:   bias_mem[p] = value;
        default:      compute_sums();
      endcase
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task check_result(logic [IDX_W-1:0] index, logic signed [ACC_W-1:0] sum,
                      logic last_flag);
      gemv_out_t want;
      if (expected_sums.size() == 0) begin
        report($sformatf("unexpected result index %0d sum %0d", index, sum));
        return;
      end
      want = expected_sums.pop_front();
      if (index !== want.index)
        report($sformatf("index %0d, wanted %0d", index, want.index));
      if (sum !== want.sum)
        report($sformatf("sum at index %0d is %0d, wanted %0d", want.index, sum, want.sum));
      if (last_flag !== want.last)
        report($sformatf("last at index %0d is %b, wanted %b", want.index, last_flag,
                         want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [OP_W-1:0] opcode;
  logic [IDX_W-1:0] row_index;
  logic [IDX_W-1:0] col_index;
  logic [IDX_W-1:0] position;
  logic signed [ELEM_W-1:0] element_value;
  logic out_valid;
  logic out_stall;
  logic [IDX_W-1:0] result_index;
  logic signed [ACC_W-1:0] result_value;
  logic last;

  gemv_checker sb = new();

  // Which store entries hold a written value. A compute may only read entries
  // that were written, so any gap in the active region is filled before it.
  bit mat_set [MAX_DIM*MAX_DIM];
  bit vec_set [MAX_DIM];
  bit bias_set [MAX_DIM];

  // When set, gap filling writes the most negative element so that the dot
  // products reach their largest magnitude.
  bit fill_extreme;

  int burst_left;
  int items_sent;
  int random_start;
  int stall_run;
  int stall_style;
  int unsigned cycles;

  matrix_vector_multiply_add #(
    .MAX_DIM(MAX_DIM),
    .ELEM_WIDTH(ELEM_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .row_index(row_index),
    .col_index(col_index),
    .position(position),
    .element_value(element_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_index(result_index),
    .result_value(result_value),
    .last(last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // The run is cut off if it takes far longer than any correct run could.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // The result side stalls on a pattern of its own: stretches with no stall at
  // all, stretches of coin-flip stalls, and stretches where it is mostly
  // stalled. Each stretch has a random length.
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_style <= $urandom_range(0, 2);
      stall_run <= $urandom_range(8, 120);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 1);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Every result transfer is checked against the oldest expected sum. Values
  // are read right after the edge, so they are the ones the edge sampled.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(result_index, result_value, last);
  end

  // Element values lean toward the extremes of the signed Q8.8 range.
  function automatic logic [ELEM_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // A random index for a field that the item does not use.
  function automatic logic [IDX_W-1:0] any_index();
    return IDX_W'($urandom);
  endfunction

  // Offers one input transfer and returns at the edge that takes it. The
  // sender works in bursts: when one burst is used up, valid may drop for a
  // random gap before the next. An offered transfer can never be withdrawn,
  // so its effect on the expected sums is worked out when it is offered; the
  // results of a compute can only come after that.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] r, c, p,
                           input logic [ELEM_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    opcode <= op;
    row_index <= r;
    col_index <= c;
    position <= p;
    element_value <= value;
    sb.note_item(op, r, c, p, value);
    case (op)
      OP_WR_MATRIX: mat_set[{r, c}] = 1'b1;
      OP_WR_VECTOR: vec_set[p] = 1'b1;
      OP_WR_BIAS:   bias_set[p] = 1'b1;
      default: ;
    endcase
    items_sent++;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  // Drops valid and waits until every expected result has been taken, then
  // waits out SETTLE_CYCLES so that nothing is left in flight.
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    sb.set_register(index, data);
    @(posedge clk);
  endtask

  // Writes every store entry that the next compute reads and that has not been
  // written yet. Unused fields carry random values.
  task automatic fill_missing();
    int nr;
    int nc;
    int nv;
    logic [MODE_W-1:0] m;
    logic [ELEM_W-1:0] value;
    nr = sb.dim_of(sb.rows_reg);
    nc = sb.dim_of(sb.cols_reg);
    m = sb.active_mode();
    nv = (m == MODE_VXM) ? nr : nc;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        if (!mat_set[r*MAX_DIM + c]) begin
          value = fill_extreme ? 16'h8000 : pick_value();
          send_item(OP_WR_MATRIX, IDX_W'(r), IDX_W'(c), any_index(), value);
        end
      end
    end
    for (int k = 0; k < nv; k++) begin
      if (!vec_set[k]) begin
        value = fill_extreme ? 16'h8000 : pick_value();
        send_item(OP_WR_VECTOR, any_index(), any_index(), IDX_W'(k), value);
      end
    end
    if (m == MODE_MXV_BIAS) begin
      for (int k = 0; k < nr; k++) begin
        if (!bias_set[k]) begin
          value = fill_extreme ? 16'h8000 : pick_value();
          send_item(OP_WR_BIAS, any_index(), any_index(), IDX_W'(k), value);
        end
      end
    end
  endtask

  // One well-formed round: a few loads, mostly inside the active region and
  // now and then anywhere in the stores, then whatever the compute still needs,
  // then the compute itself with random unused fields.
  task automatic random_round();
    int n_loads;
    int nr;
    int nc;
    int span;
    logic [OP_W-1:0] op;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
    logic [IDX_W-1:0] p;
    nr = sb.dim_of(sb.rows_reg);
    nc = sb.dim_of(sb.cols_reg);
    span = (nr > nc) ? nr : nc;
    n_loads = $urandom_range(0, 8);
    repeat (n_loads) begin
      op = OP_W'($urandom_range(0, 2));
      if ($urandom_range(0, 4) == 0) begin
        r = any_index();
        c = any_index();
        p = any_index();
      end else begin
        r = IDX_W'($urandom_range(0, nr - 1));
        c = IDX_W'($urandom_range(0, nc - 1));
        p = IDX_W'($urandom_range(0, span - 1));
      end
      send_item(op, r, c, p, pick_value());
    end
    fill_missing();
    send_item(OP_COMPUTE, any_index(), any_index(), any_index(), ELEM_W'($urandom));
  endtask

  // A phase programs the registers while the block is idle and then runs a
  // number of rounds. The mode word carries random upper bits, which the
  // register drops, and the unused register index is written now and then.
  task automatic run_phase(input logic [CNT_W-1:0] rows_raw, cols_raw,
                           input logic [MODE_W-1:0] mode_code, input int rounds);
    logic [CFG_W-1:0] mode_word;
    mode_word = CFG_W'($urandom);
    mode_word[MODE_W-1:0] = mode_code;
    wait_idle();
    if ($urandom_range(0, 3) == 0) cfg_write(CFG_SPARE, CFG_W'($urandom));
    cfg_write(CFG_ROW_COUNT, rows_raw);
    cfg_write(CFG_COL_COUNT, cols_raw);
    cfg_write(CFG_MODE, mode_word);
    cfg_we <= 1'b0;
    repeat (rounds) random_round();
  endtask

  // Small sizes keep the random part short; a size of zero shows up now and
  // then.
  function automatic logic [CNT_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return '0;
      default: return CNT_W'($urandom_range(1, 8));
    endcase
  endfunction

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_ROW_COUNT;
    cfg_data <= '0;
    in_valid <= 1'b0;
    opcode <= OP_WR_MATRIX;
    row_index <= '0;
    col_index <= '0;
    position <= '0;
    element_value <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed items at the reset configuration, a single row and column in
    // matrix times vector mode. The first compute multiplies the two most
    // negative elements, the second mixes the largest positive and the most
    // negative one. Writes at the far corners of the stores and a compute with
    // every unused field set to ones follow.
    send_item(OP_WR_MATRIX, 0, 0, any_index(), 16'h8000);
    send_item(OP_WR_VECTOR, any_index(), any_index(), 0, 16'h8000);
    send_item(OP_COMPUTE, any_index(), any_index(), any_index(), ELEM_W'($urandom));
    send_item(OP_WR_MATRIX, 0, 0, any_index(), 16'h7fff);
    send_item(OP_COMPUTE, any_index(), any_index(), any_index(), ELEM_W'($urandom));
    send_item(OP_WR_MATRIX, 63, 63, 0, 16'h7fff);
    send_item(OP_WR_VECTOR, 0, 0, 63, 16'h7fff);
    send_item(OP_WR_BIAS, 63, 63, 63, 16'h8000);
    send_item(OP_WR_BIAS, 0, 0, 0, 16'h7fff);
    send_item(OP_WR_MATRIX, 0, 63, 63, 16'h0001);
    send_item(OP_WR_MATRIX, 63, 0, 0, 16'hffff);
    send_item(OP_COMPUTE, 63, 63, 63, 16'hffff);
    send_item(OP_WR_MATRIX, 0, 0, 63, 16'h0000);
    send_item(OP_COMPUTE, 0, 0, 0, 16'h0000);

    // A 64-term sum in vector times matrix mode with a row count above the
    // maximum, its gaps filled with the most negative element to push the sum
    // toward its largest magnitude, then 64 results from the same matrix column in
    // matrix times vector mode. Then sizes of zero, the unused mode and the
    // smallest transposed case.
    fill_extreme = 1'b1;
    run_phase(127, 1, MODE_VXM, 1);
    run_phase(64, 1, MODE_MXV, 1);
    fill_extreme = 1'b0;
    run_phase(0, 0, MODE_MXV_BIAS, 2);
    run_phase(3, 2, MODE_SPARE, 2);
    run_phase(1, 1, MODE_VXM, 2);

    // Random phases, small sizes, until enough items have gone in.
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS)
      run_phase(pick_size(), pick_size(), MODE_W'($urandom_range(0, 3)),
                int'($urandom_range(2, 6)));

    wait_idle();
    repeat (24) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
